// ===== design/corner_autotile_sprite_select_defines.svh =====
// assertion macros used by the top-level design file
`ifndef CORNER_AUTOTILE_SPRITE_SELECT_DEFINES_SVH
`define CORNER_AUTOTILE_SPRITE_SELECT_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled while in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/cass_pkg.sv =====
package cass_pkg;

	localparam int CoordW  = 12;
	localparam int CornerW = 8;
	localparam int TypeW   = 8;
	localparam int SrcXW   = 18;
	localparam int SrcYW   = 10;
	localparam int TileW   = 8;
	localparam int HashW   = 29;
	localparam int QuotW   = 19;
	localparam int RemW    = 11;
	localparam int RndW    = 15;

	// register indexes
	localparam logic [0:0] REG_TILE_WIDTH  = 1'b0;
	localparam logic [0:0] REG_TILE_HEIGHT = 1'b1;

	localparam logic [TileW-1:0] TILE_WIDTH_RST  = 8'd16;
	localparam logic [TileW-1:0] TILE_HEIGHT_RST = 8'd16;

	// diagonal corner masks
	localparam logic [3:0] MASK_DIAG_MAIN = 4'b1001;
	localparam logic [3:0] MASK_DIAG_ANTI = 4'b0110;

	// variant hash constants
	localparam logic [HashW-1:0] HashSeed = 29'd291123835;
	localparam logic [RemW-1:0]  HashMod  = 11'd1221;
	// reciprocal for the modulo, exact for any dividend below 2^29
	localparam logic [29:0]      ModRecip = 30'((64'd1 << 40) / 1221 + 1);
	localparam logic [17:0]      LcgMul   = 18'd214013;
	localparam logic [30:0]      LcgAdd   = 31'd2531011;

	typedef struct packed {
		logic [CoordW-1:0]  cell_x;
		logic [CoordW-1:0]  cell_y;
		logic [CornerW-1:0] corner_top_left;
		logic [CornerW-1:0] corner_top_right;
		logic [CornerW-1:0] corner_bottom_left;
		logic [CornerW-1:0] corner_bottom_right;
	} cell_t;

	typedef struct packed {
		logic [TypeW-1:0] tile_type;
		logic [SrcXW-1:0] source_x;
		logic [SrcYW-1:0] source_y;
		logic             last_sprite;
	} sprite_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic load;
		logic issue;
	} cass_cmd_t;

	typedef struct packed {
		logic pending;
		logic last;
		logic pipe_busy;
	} cass_stat_t;

	// base sprite cell; col_var adds a variant of 0..1, row_var one of 0..2
	typedef struct packed {
		logic [1:0] col;
		logic [2:0] row;
		logic       col_var;
		logic       row_var;
	} sprite_entry_t;

	function automatic sprite_entry_t sprite_lookup(input logic [3:0] mask);
		sprite_entry_t e;
		unique case (mask)
			4'd1:    e = '{col: 2'd0, row: 3'd0, col_var: 1'b0, row_var: 1'b0};
			4'd2:    e = '{col: 2'd3, row: 3'd0, col_var: 1'b0, row_var: 1'b0};
			4'd3:    e = '{col: 2'd1, row: 3'd0, col_var: 1'b1, row_var: 1'b0};
			4'd4:    e = '{col: 2'd0, row: 3'd4, col_var: 1'b0, row_var: 1'b0};
			4'd5:    e = '{col: 2'd0, row: 3'd1, col_var: 1'b0, row_var: 1'b1};
			4'd7:    e = '{col: 2'd2, row: 3'd3, col_var: 1'b0, row_var: 1'b0};
			4'd8:    e = '{col: 2'd3, row: 3'd4, col_var: 1'b0, row_var: 1'b0};
			4'd10:   e = '{col: 2'd3, row: 3'd1, col_var: 1'b0, row_var: 1'b1};
			4'd11:   e = '{col: 2'd1, row: 3'd3, col_var: 1'b0, row_var: 1'b0};
			4'd12:   e = '{col: 2'd1, row: 3'd4, col_var: 1'b1, row_var: 1'b0};
			4'd13:   e = '{col: 2'd2, row: 3'd2, col_var: 1'b0, row_var: 1'b0};
			4'd14:   e = '{col: 2'd1, row: 3'd2, col_var: 1'b0, row_var: 1'b0};
			4'd15:   e = '{col: 2'd1, row: 3'd1, col_var: 1'b1, row_var: 1'b0};
			// empty and diagonal masks never reach the table
			default: e = '{col: 2'd0, row: 3'd0, col_var: 1'b0, row_var: 1'b0};
		endcase
		return e;
	endfunction

	// residue mod 3 by folding base-4 digits (4 = 1 mod 3)
	function automatic logic [1:0] mod3_15(input logic [RndW-1:0] r);
		logic [15:0] pad;
		logic [4:0]  dsum;
		logic [2:0]  f;
		logic [2:0]  g;
		pad  = {1'b0, r};
		dsum = '0;
		for (int i = 0; i < 8; i++) begin
			dsum = dsum + 5'(pad[2*i +: 2]);
		end
		f = 3'(dsum[1:0]) + 3'(dsum[3:2]) + 3'(dsum[4]);
		g = 3'(f[1:0]) + 3'(f[2]);
		return (g >= 3'd3) ? 2'(g - 3'd3) : g[1:0];
	endfunction

endpackage

// ===== design/corner_autotile_sprite_select.sv =====
// corner autotile sprite selector
// one transaction in: a map cell (position and four corner values, 0 empty,
// else terrain type plus one), taken on a clock edge with start high and busy low
// results out: sprites on result, each marked by result_valid for
// one cycle each; sprites of a cell come back to back in ascending type order,
// the final one flagged by last_sprite; a cell gives zero to four sprites
// config: cfg_write with cfg_index/cfg_data sets tile width (0) or height (1);
// the user is bound to write only while busy is low; the block leaves that to the user
// timing: each sprite passes through the 7-stage hash and lookup pipeline,
// one sprite entering per cycle, and is taken at the clock edge at the end
// of its valid cycle; busy stays high until the last sprite has left the
// pipeline, and an empty cell goes straight from issue to drain to idle
// the receiver cannot hold results off, so nothing ever waits on the output
// reset clears the controller, remain_q and the pipeline valids; sizes go to 16
`include "corner_autotile_sprite_select_defines.svh"

module corner_autotile_sprite_select (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  cass_pkg::cell_t            map_cell,
	output logic                       result_valid,
	output cass_pkg::sprite_t          result,
	input  logic                       cfg_write,
	input  logic [0:0]                 cfg_index,
	input  logic [cass_pkg::TileW-1:0] cfg_data
);
	import cass_pkg::*;

	cass_cmd_t  cmd;
	cass_stat_t stat;

	// sequencer: loads the cell, issues one sprite per cycle, waits for drain
	cass_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// cell registers, corner scan, variant hash pipeline and output register
	cass_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.map_cell     (map_cell),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	// a sprite only ever appears inside a transaction
	`ASSERT_IMP(a_strobe_in_busy, clk, arst_n, result_valid, busy)
	// an accepted cell keeps the block busy on the next cycle
	`ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// sprites of one cell follow each other without gaps
	`ASSERT_NXT(a_burst, clk, arst_n, result_valid && !result.last_sprite, result_valid)
	// nothing follows the last sprite straight away
	`ASSERT_NXT(a_last_gap, clk, arst_n, result_valid && result.last_sprite, !result_valid)

endmodule

// ===== design/cass_ctrl.sv =====
module cass_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  cass_pkg::cass_stat_t stat,
	output cass_pkg::cass_cmd_t  cmd,
	output logic                busy
);
	import cass_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load   = 1'b1;
					state_next = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (stat.pending) begin
					cmd.issue = 1'b1;
					if (stat.last) begin
						state_next = ST_DRAIN;
					end
				end else begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== design/cass_datapath.sv =====
module cass_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cass_pkg::cell_t            map_cell,
	input  cass_pkg::cass_cmd_t        cmd,
	output cass_pkg::cass_stat_t       stat,
	input  logic                       cfg_write,
	input  logic [0:0]                 cfg_index,
	input  logic [cass_pkg::TileW-1:0] cfg_data,
	output logic                       result_valid,
	output cass_pkg::sprite_t          result
);
	import cass_pkg::*;

	// cell registers, held for the whole transaction; remain_q marks corners still to issue
	logic [CoordW-1:0]  x_q;
	logic [CoordW-1:0]  y_q;
	logic [CornerW-1:0] corner_q [4];
	logic [3:0]         remain_q;

	logic [TileW-1:0] tile_width_q;
	logic [TileW-1:0] tile_height_q;

	// sprite selection
	logic [CornerW-1:0] lo;
	logic [3:0]         eq_mask;
	logic [3:0]         spr_mask;
	logic [3:0]         remain_next;
	logic [TypeW-1:0]   issue_type;
	logic [HashW-1:0]   hash0;

	// pipeline
	logic             valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic [TypeW-1:0] type_s1, type_s2, type_s3, type_s4, type_s5, type_s6;
	logic [3:0]       mask_s1, mask_s2, mask_s3, mask_s4, mask_s5;
	logic             last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic [HashW-1:0] hash0_s1, hash0_s2, hash0_s3;
	logic [QuotW-1:0] quot_s2;
	logic [RemW-1:0]  rem_s3;
	logic [31:0]      hmix_s4;
	logic [RndW-1:0]  rnd_s5;
	logic [1:0]       col_s6;
	logic [2:0]       row_s6;

	logic [58:0]      quot_prod;
	logic [29:0]      quot_mul;
	logic [HashW-1:0] rem_full;
	logic [31:0]      mixed;
	logic [49:0]      lcg_prod;
	logic [30:0]      lcg_sum;
	sprite_entry_t    entry;
	logic [10:0]      src_y_full;

	// lowest remaining corner value and the corners that share it
	always_comb begin
		lo      = '1;
		eq_mask = '0;
		for (int i = 0; i < 4; i++) begin
			if (remain_q[3-i] && (corner_q[i] < lo)) begin
				lo = corner_q[i];
			end
		end
		for (int i = 0; i < 4; i++) begin
			eq_mask[3-i] = remain_q[3-i] && (corner_q[i] == lo);
		end
		// a diagonal takes its upper corner first, the other one follows
		if (eq_mask == MASK_DIAG_MAIN) begin
			spr_mask = 4'b1000;
		end else if (eq_mask == MASK_DIAG_ANTI) begin
			spr_mask = 4'b0100;
		end else begin
			spr_mask = eq_mask;
		end
		remain_next = remain_q & ~spr_mask;
		issue_type  = lo - 8'd1;
		hash0       = (HashW'(x_q) * 29'd17) ^ (HashW'(y_q) * 29'd11)
		            ^ (HashW'(issue_type) * 29'd7 + HashSeed);
	end

	assign stat.pending   = |remain_q;
	assign stat.last      = (remain_next == 4'b0000);
	assign stat.pipe_busy = valid_s1 | valid_s2 | valid_s3 | valid_s4 | valid_s5
	                      | valid_s6 | valid_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q      <= '0;
			tile_width_q  <= TILE_WIDTH_RST;
			tile_height_q <= TILE_HEIGHT_RST;
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			valid_s3      <= 1'b0;
			valid_s4      <= 1'b0;
			valid_s5      <= 1'b0;
			valid_s6      <= 1'b0;
			valid_s7      <= 1'b0;
		end else begin
			if (cmd.load) begin
				remain_q <= {map_cell.corner_top_left != '0, map_cell.corner_top_right != '0,
				             map_cell.corner_bottom_left != '0,
				             map_cell.corner_bottom_right != '0};
			end else if (cmd.issue) begin
				remain_q <= remain_next;
			end
			if (cfg_write) begin
				unique case (cfg_index)
					REG_TILE_WIDTH:  tile_width_q  <= cfg_data;
					REG_TILE_HEIGHT: tile_height_q <= cfg_data;
					default: ;
				endcase
			end
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// hash datapath
	assign quot_prod = 59'(hash0_s1) * 59'(ModRecip);
	assign quot_mul  = 30'(quot_s2) * 30'(HashMod);
	assign rem_full  = hash0_s2 - quot_mul[HashW-1:0];
	assign mixed     = ((32'(rem_s3) ^ 32'(hash0_s3) ^ (32'(x_q) * 32'd19))
	                 + 32'(y_q) * 32'd31) + 32'(type_s3);
	assign lcg_prod  = 50'(hmix_s4) * 50'(LcgMul);
	assign lcg_sum   = lcg_prod[30:0] + LcgAdd;
	assign entry     = sprite_lookup(mask_s5);
	assign src_y_full = 11'(row_s6) * 11'(tile_height_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q         <= map_cell.cell_x;
			y_q         <= map_cell.cell_y;
			corner_q[0] <= map_cell.corner_top_left;
			corner_q[1] <= map_cell.corner_top_right;
			corner_q[2] <= map_cell.corner_bottom_left;
			corner_q[3] <= map_cell.corner_bottom_right;
		end

		type_s1  <= issue_type;
		mask_s1  <= spr_mask;
		last_s1  <= stat.last;
		hash0_s1 <= hash0;

		type_s2  <= type_s1;
		mask_s2  <= mask_s1;
		last_s2  <= last_s1;
		hash0_s2 <= hash0_s1;
		quot_s2  <= quot_prod[58:40];

		type_s3  <= type_s2;
		mask_s3  <= mask_s2;
		last_s3  <= last_s2;
		hash0_s3 <= hash0_s2;
		rem_s3   <= rem_full[RemW-1:0];

		type_s4  <= type_s3;
		mask_s4  <= mask_s3;
		last_s4  <= last_s3;
		hmix_s4  <= mixed * 32'd29;

		type_s5  <= type_s4;
		mask_s5  <= mask_s4;
		last_s5  <= last_s4;
		rnd_s5   <= lcg_sum[30:16];

		type_s6  <= type_s5;
		last_s6  <= last_s5;
		col_s6   <= entry.col + (entry.col_var ? {1'b0, rnd_s5[0]} : 2'd0);
		row_s6   <= entry.row + (entry.row_var ? {1'b0, mod3_15(rnd_s5)} : 3'd0);

		result.tile_type   <= type_s6;
		result.source_x    <= SrcXW'({type_s6, col_s6}) * SrcXW'(tile_width_q);
		result.source_y    <= src_y_full[SrcYW-1:0];
		result.last_sprite <= last_s6;
	end

	assign result_valid = valid_s7;

endmodule
